FILE: rtl/pffa_pkg.sv
// Shared types and constants for the page frame free-list allocator.
`default_nettype none
package pffa_pkg;

	localparam int PAGE_BITS = 12;
	localparam int ADDR_W    = 32;
	localparam int PN_W      = ADDR_W - PAGE_BITS;
	localparam int MAX_PAGES = 32768;
	localparam int STK_AW    = $clog2(MAX_PAGES);
	localparam int CNT_W     = $clog2(MAX_PAGES + 1);

	typedef enum logic [1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_FREE  = 2'd1,
		FUNC_RANGE = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OOM     = 2'd1,
		ST_ILLEGAL = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic    pop;
		logic    push_in;
		logic    load_range;
		logic    push_range;
		logic    res_load;
		status_t res_code;
		logic    res_ram;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic free_illegal;
		logic range_done;
		logic range_illegal;
	} stat_t;

endpackage
`default_nettype wire

FILE: rtl/pffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pffa_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 32768,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/pffa_ctrl.sv
// Controller state machine: request decode, range sequencing, result hand-off.
`default_nettype none
module pffa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire logic [1:0]      s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	input  wire pffa_pkg::stat_t stat,
	output pffa_pkg::cmd_t       cmd
);
	import pffa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RANGE,
		S_DONE
	} state_t;

	state_t state_q;
	logic   m_valid_q;
	func_t  func;

	assign func          = func_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.res_code = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					unique case (func)
						FUNC_ALLOC: begin
							cmd.res_load = 1'b1;
							if (stat.empty) begin
								cmd.res_code = ST_OOM;
							end else begin
								cmd.pop     = 1'b1;
								cmd.res_ram = 1'b1;
							end
						end
						FUNC_FREE: begin
							cmd.res_load = 1'b1;
							priority if (stat.free_illegal) begin
								cmd.res_code = ST_ILLEGAL;
							end else if (stat.full) begin
								cmd.res_code = ST_FULL;
							end else begin
								cmd.push_in = 1'b1;
							end
						end
						FUNC_RANGE: begin
							cmd.load_range = 1'b1;
						end
						default: begin
							cmd.res_load = 1'b1;
						end
					endcase
				end
			end
			S_RANGE: begin
				priority if (stat.range_done) begin
					cmd.res_load = 1'b1;
				end else if (stat.range_illegal) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_ILLEGAL;
				end else if (stat.full) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_FULL;
				end else begin
					cmd.push_range = 1'b1;
				end
			end
			S_DONE: begin
				cmd.out_load = !m_valid_q || m_axis_tready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= (func == FUNC_RANGE) ? S_RANGE : S_DONE;
					end
				end
				S_RANGE: begin
					if (cmd.res_load) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |=> m_valid_q)
		else $error("result beat dropped before it was taken");

	a_range_ends_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RANGE) && cmd.res_load |=> (state_q == S_DONE))
		else $error("range finished without reporting a result");

endmodule
`default_nettype wire

FILE: rtl/pffa_dp.sv
// Datapath: free-page stack, stack pointer, range cursor and result registers.
`default_nettype none
module pffa_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [pffa_pkg::ADDR_W-1:0]   cfg_wr_data,
	input  wire logic [pffa_pkg::ADDR_W-1:0]   in_addr,
	input  wire logic [pffa_pkg::ADDR_W-1:0]   in_range_end,
	input  wire pffa_pkg::cmd_t                cmd,
	output pffa_pkg::stat_t                    stat,
	output logic      [1:0]                    out_status,
	output logic      [pffa_pkg::ADDR_W-1:0]   out_page_addr
);
	import pffa_pkg::*;

	logic [ADDR_W-1:0] kend_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cnt_dec;
	logic [PN_W:0]     pn_q;
	logic [PN_W-1:0]   end_pg_q;
	logic [PN_W:0]     pn_start;
	status_t           res_status_q;
	logic              res_ram_q;
	logic [1:0]        m_status_q;
	logic [ADDR_W-1:0] m_page_q;
	logic              ram_we;
	logic [PN_W-1:0]   ram_wdata;
	logic [PN_W-1:0]   ram_rdata;

	assign cnt_dec  = count_q - CNT_W'(1);
	assign pn_start = {1'b0, in_addr[ADDR_W-1:PAGE_BITS]}
		+ (PN_W + 1)'(|in_addr[PAGE_BITS-1:0]);

	assign stat.empty         = (count_q == '0);
	assign stat.full          = (count_q >= CNT_W'(MAX_PAGES));
	assign stat.free_illegal  = (|in_addr[PAGE_BITS-1:0]) || (in_addr < kend_q);
	assign stat.range_done    = (pn_q >= {1'b0, end_pg_q});
	assign stat.range_illegal = ({pn_q, {PAGE_BITS{1'b0}}} < {1'b0, kend_q});

	assign ram_we    = cmd.push_in || cmd.push_range;
	assign ram_wdata = cmd.push_in ? in_addr[ADDR_W-1:PAGE_BITS] : pn_q[PN_W-1:0];

	pffa_ram #(
		.WIDTH(PN_W),
		.DEPTH(MAX_PAGES)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[STK_AW-1:0]),
		.wdata(ram_wdata),
		.re   (cmd.pop),
		.raddr(cnt_dec[STK_AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kend_q  <= '0;
			count_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				kend_q <= cfg_wr_data;
			end
			if (cmd.pop) begin
				count_q <= cnt_dec;
			end else if (ram_we) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_range) begin
			pn_q     <= pn_start;
			end_pg_q <= in_range_end[ADDR_W-1:PAGE_BITS];
		end else if (cmd.push_range) begin
			pn_q <= pn_q + (PN_W + 1)'(1);
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_code;
			res_ram_q    <= cmd.res_ram;
		end
		if (cmd.out_load) begin
			m_status_q <= res_status_q;
			m_page_q   <= res_ram_q ? {ram_rdata, {PAGE_BITS{1'b0}}} : '0;
		end
	end

	assign out_status    = m_status_q;
	assign out_page_addr = m_page_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PAGES))
		else $error("stack pointer past stack depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !stat.empty)
		else $error("pop from empty stack");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !stat.full && !(cmd.push_in && cmd.push_range))
		else $error("push onto full stack or two pushes at once");

	a_pop_moves_pointer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> (count_q == $past(cnt_dec)))
		else $error("stack pointer not decremented on pop");

endmodule
`default_nettype wire

FILE: rtl/page_frame_free_list_allocator.sv
// Top level of the page frame free-list allocator.
// Free page frames sit on a LIFO stack of 20-bit page numbers held in a 32768-entry
// single-port-write RAM. An alloc or single free registers its result and then moves it
// into the output register once that is free; a range free first pushes its pages until
// its terminating check, since the stack RAM takes one push per cycle. One request is
// in flight at a time; a new request is accepted while the previous result beat still
// waits in the output register. The stack RAM is not cleared: only entries below the
// fill count are ever read. kernel_end_addr is written through cfg_wr_en/cfg_wr_data
// and should only change while no request is in flight.
`default_nettype none
module page_frame_free_list_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,    // kernel_end_addr
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [31:0] addr, [63:32] range_end
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,   // [31:0] page_addr
	output logic      [1:0]  m_axis_tuser    // [1:0] status
);
	import pffa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pffa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.stat         (stat),
		.cmd          (cmd)
	);

	pffa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_addr      (s_axis_tdata[31:0]),
		.in_range_end (s_axis_tdata[63:32]),
		.cmd          (cmd),
		.stat         (stat),
		.out_status   (m_axis_tuser),
		.out_page_addr(m_axis_tdata)
	);

endmodule
`default_nettype wire
